// ===== sv/gds_pkg.sv =====
// Shared types, constants and month-length function for the Gregorian date stepper.
`default_nettype none

package gds_pkg;

   typedef enum logic [1:0] {
      MODE_NEXT  = 2'd0,
      MODE_PREV  = 2'd1,
      MODE_CHECK = 2'd2,
      MODE_SPARE = 2'd3
   } mode_type;

   localparam int unsigned DAY_W   = 5;
   localparam int unsigned MONTH_W = 4;
   localparam int unsigned YEAR_W  = 15;

   localparam logic [YEAR_W-1:0]  YEAR_MIN = 15'd1900;
   localparam logic [YEAR_W-1:0]  YEAR_MAX = 15'd30000;
   localparam logic [YEAR_W-1:0]  YEAR_TOP = 15'd32767;

   localparam logic [DAY_W-1:0]   DAY_TOP   = 5'd31;
   localparam logic [MONTH_W-1:0] MONTH_TOP = 4'd15;
   localparam logic [MONTH_W-1:0] JAN       = 4'd1;
   localparam logic [MONTH_W-1:0] FEB       = 4'd2;
   localparam logic [MONTH_W-1:0] DEC       = 4'd12;

   // year / 100 == (year * 5243) >> 19 for every 15-bit year
   localparam int unsigned        DIV100_MUL_W = 13;
   localparam logic [12:0]        DIV100_MUL   = 13'd5243;
   localparam int unsigned        DIV100_SHIFT = 19;
   localparam int unsigned        QUOT_W       = 9;
   localparam int unsigned        PROD_W       = YEAR_W + DIV100_MUL_W;
   localparam logic [6:0]         HUNDRED      = 7'd100;

   function automatic logic [DAY_W-1:0] month_length(input logic [MONTH_W-1:0] month,
                                                     input logic leap);
      logic [DAY_W-1:0] len;
      begin
         unique case (month)
            FEB:                               len = leap ? 5'd29 : 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11:           len = 5'd30;
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8,
            4'd10, 4'd12:                      len = 5'd31;
            default:                           len = 5'd0;
         endcase
         return len;
      end
   endfunction

endpackage

`default_nettype wire

// ===== sv/gregorian_date_step_core.sv =====
// Top level of the Gregorian date stepper: next day, previous day or check.
// Throughput: one request per cycle; busy stays low, since the three register
// stages (divide-by-100 multiply, date step, range check) never wait.
// The receiver cannot stall; each result shows for one cycle.
// Reset clears the stage valid bits and drops any request still in flight.
`default_nettype none

module gregorian_date_step_core (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                start,
   output logic                                     busy,
   input  wire logic [1:0]                          req_mode,
   input  wire logic [gds_pkg::DAY_W-1:0]           req_day,
   input  wire logic [gds_pkg::MONTH_W-1:0]         req_month,
   input  wire logic [gds_pkg::YEAR_W-1:0]          req_year,
   output logic                                     rsp_strobe,
   output logic [gds_pkg::DAY_W-1:0]                rsp_out_day,
   output logic [gds_pkg::MONTH_W-1:0]              rsp_out_month,
   output logic [gds_pkg::YEAR_W-1:0]               rsp_out_year,
   output logic                                     rsp_result_valid
);

   logic                              s1_valid_ff;
   gds_pkg::mode_type                 s1_mode_ff;
   logic [gds_pkg::DAY_W-1:0]         s1_day_ff;
   logic [gds_pkg::MONTH_W-1:0]       s1_month_ff;
   logic [gds_pkg::YEAR_W-1:0]        s1_year_ff;
   logic                              s1_leap;

   logic                              s2_valid_ff;
   logic [gds_pkg::DAY_W-1:0]         s2_day_ff,   s2_day_in;
   logic [gds_pkg::MONTH_W-1:0]       s2_month_ff, s2_month_in;
   logic [gds_pkg::YEAR_W-1:0]        s2_year_ff,  s2_year_in;
   logic                              s2_over_ff,  s2_over_in;
   logic                              s2_leap_ff;

   logic                              s3_valid_ff;
   logic [gds_pkg::DAY_W-1:0]         s3_day_ff;
   logic [gds_pkg::MONTH_W-1:0]       s3_month_ff;
   logic [gds_pkg::YEAR_W-1:0]        s3_year_ff;
   logic                              s3_ok_ff, s3_ok_in;

   logic [gds_pkg::DAY_W-1:0]         s1_len;
   logic [gds_pkg::MONTH_W-1:0]       s1_month_dec;

   assign busy = 1'b0;

   gds_leap u_leap (
      .clock (clock),
      .year  (req_year),
      .leap  (s1_leap)
   );

   // stage 1: capture request
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= start;
      end
      s1_mode_ff  <= gds_pkg::mode_type'(req_mode);
      s1_day_ff   <= req_day;
      s1_month_ff <= req_month;
      s1_year_ff  <= req_year;
   end

   // stage 2: step the date (check and spare mode pass it through), saturate fields that leave their range
   assign s1_len       = gds_pkg::month_length(s1_month_ff, s1_leap);
   assign s1_month_dec = s1_month_ff - 4'd1;

   always_comb begin
      s2_day_in   = s1_day_ff;
      s2_month_in = s1_month_ff;
      s2_year_in  = s1_year_ff;
      s2_over_in  = 1'b0;
      unique case (s1_mode_ff)
         gds_pkg::MODE_NEXT: begin
            if (s1_day_ff == s1_len) begin
               s2_day_in = 5'd1;
               if (s1_month_ff == gds_pkg::DEC) begin
                  s2_month_in = gds_pkg::JAN;
                  if (s1_year_ff == gds_pkg::YEAR_TOP) begin
                     s2_over_in = 1'b1;
                  end else begin
                     s2_year_in = s1_year_ff + 15'd1;
                  end
               end else if (s1_month_ff == gds_pkg::MONTH_TOP) begin
                  s2_over_in = 1'b1;
               end else begin
                  s2_month_in = s1_month_ff + 4'd1;
               end
            end else if (s1_day_ff == gds_pkg::DAY_TOP) begin
               s2_over_in = 1'b1;
            end else begin
               s2_day_in = s1_day_ff + 5'd1;
            end
         end
         gds_pkg::MODE_PREV: begin
            if (s1_day_ff == 5'd1) begin
               if (s1_month_ff == gds_pkg::JAN) begin
                  s2_day_in   = gds_pkg::DAY_TOP;
                  s2_month_in = gds_pkg::DEC;
                  if (s1_year_ff == '0) begin
                     s2_over_in = 1'b1;
                  end else begin
                     s2_year_in = s1_year_ff - 15'd1;
                  end
               end else if (s1_month_ff == '0) begin
                  s2_day_in  = '0;
                  s2_over_in = 1'b1;
               end else begin
                  s2_month_in = s1_month_dec;
                  s2_day_in   = gds_pkg::month_length(s1_month_dec, s1_leap);
               end
            end else if (s1_day_ff == '0) begin
               s2_over_in = 1'b1;
            end else begin
               s2_day_in = s1_day_ff - 5'd1;
            end
         end
         gds_pkg::MODE_CHECK, gds_pkg::MODE_SPARE: begin
            s2_over_in = 1'b0;
         end
         default: begin
            s2_over_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= s1_valid_ff;
      end
      s2_day_ff   <= s2_day_in;
      s2_month_ff <= s2_month_in;
      s2_year_ff  <= s2_year_in;
      s2_over_ff  <= s2_over_in;
      s2_leap_ff  <= s1_leap;
   end

   // stage 3: range check; a changed year only comes with January or December
   assign s3_ok_in = !s2_over_ff
                     && (s2_year_ff >= gds_pkg::YEAR_MIN) && (s2_year_ff <= gds_pkg::YEAR_MAX)
                     && (s2_month_ff >= gds_pkg::JAN) && (s2_month_ff <= gds_pkg::DEC)
                     && (s2_day_ff != '0)
                     && (s2_day_ff <= gds_pkg::month_length(s2_month_ff, s2_leap_ff));

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else begin
         s3_valid_ff <= s2_valid_ff;
      end
      s3_day_ff   <= s2_day_ff;
      s3_month_ff <= s2_month_ff;
      s3_year_ff  <= s2_year_ff;
      s3_ok_ff    <= s3_ok_in;
   end

   assign rsp_strobe       = s3_valid_ff;
   assign rsp_out_day      = s3_day_ff;
   assign rsp_out_month    = s3_month_ff;
   assign rsp_out_year     = s3_year_ff;
   assign rsp_result_valid = s3_ok_ff;

   a_strobe_follows_request: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(start, 3))
      else $error("result strobe without a request three cycles earlier");

   a_request_gives_strobe: assert property (@(posedge clock) disable iff (reset)
      start |=> ##2 rsp_strobe)
      else $error("request did not produce a result");

   a_valid_in_range: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_result_valid) |->
         (rsp_out_month >= gds_pkg::JAN && rsp_out_month <= gds_pkg::DEC
          && rsp_out_day != '0
          && rsp_out_year >= gds_pkg::YEAR_MIN && rsp_out_year <= gds_pkg::YEAR_MAX))
      else $error("valid result outside calendar range");

   a_check_passes_date: assert property (@(posedge clock) disable iff (reset)
      (start && req_mode == gds_pkg::MODE_CHECK) |-> ##3
         (rsp_out_year == $past(req_year, 3) && rsp_out_day == $past(req_day, 3)))
      else $error("check mode altered the date");

endmodule

`default_nettype wire

// ===== sv/gds_leap.sv =====
// Leap-year test with a registered reciprocal multiply for the divide by 100.
`default_nettype none

module gds_leap (
   input  wire logic                           clock,
   input  wire logic [gds_pkg::YEAR_W-1:0]     year,
   output logic                                leap
);

   logic [gds_pkg::PROD_W-1:0]  prod;
   logic [gds_pkg::QUOT_W-1:0]  quot_ff;
   logic [gds_pkg::YEAR_W-1:0]  year_ff;
   logic [gds_pkg::YEAR_W:0]    hund;
   logic [gds_pkg::YEAR_W-1:0]  rem;

   assign prod = gds_pkg::PROD_W'(year) * gds_pkg::PROD_W'(gds_pkg::DIV100_MUL);

   always_ff @(posedge clock) begin
      quot_ff <= prod[gds_pkg::DIV100_SHIFT +: gds_pkg::QUOT_W];
      year_ff <= year;
   end

   assign hund = (gds_pkg::YEAR_W+1)'(quot_ff) * (gds_pkg::YEAR_W+1)'(gds_pkg::HUNDRED);
   assign rem  = year_ff - hund[gds_pkg::YEAR_W-1:0];

   // divisible by 400 when divisible by 100 and the quotient by 4
   assign leap = (year_ff[1:0] == 2'd0) && ((rem != '0) || (quot_ff[1:0] == 2'd0));

endmodule

`default_nettype wire

// ===== bench/gds_date_checker.sv =====
// Checker for the Gregorian date stepper: watches requests, predicts dates, compares results.
module gds_date_checker
   import gds_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   input  wire logic               busy,
   input  wire logic [1:0]         req_mode,
   input  wire logic [DAY_W-1:0]   req_day,
   input  wire logic [MONTH_W-1:0] req_month,
   input  wire logic [YEAR_W-1:0]  req_year,
   input  wire logic               rsp_strobe,
   input  wire logic [DAY_W-1:0]   rsp_out_day,
   input  wire logic [MONTH_W-1:0] rsp_out_month,
   input  wire logic [YEAR_W-1:0]  rsp_out_year,
   input  wire logic               rsp_result_valid,
   output int                      fail_count,
   output int                      pending,
   output int                      dates_checked
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [DAY_W-1:0]   day;
      logic [MONTH_W-1:0] month;
      logic [YEAR_W-1:0]  year;
      logic               valid;
   } date_t;

   date_t expected_dates[$];

   function automatic bit is_leap(int y);
      return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
   endfunction

   function automatic int days_in_month(int m, int y);
      case (m)
         2:                     return is_leap(y) ? 29 : 28;
         4, 6, 9, 11:           return 30;
         1, 3, 5, 7, 8, 10, 12: return 31;
         default:               return 0;
      endcase
   endfunction

   function automatic int clip(int v, int top);
      return (v < 0) ? 0 : ((v > top) ? top : v);
   endfunction

   function automatic date_t step_date(mode_type mode, logic [DAY_W-1:0] d_in,
                                       logic [MONTH_W-1:0] m_in, logic [YEAR_W-1:0] y_in);
      int d;
      int m;
      int y;
      int rd;
      int rm;
      int ry;
      bit over;
      date_t r;
      d = d_in;
      m = m_in;
      y = y_in;
      case (mode)
         MODE_NEXT: begin
            if (d == days_in_month(m, y)) begin
               d = 1;
               if (m == int'(DEC)) begin
                  m = JAN;
                  y = y + 1;
               end else begin
                  m = m + 1;
               end
            end else begin
               d = d + 1;
            end
         end
         MODE_PREV: begin
            if (d == 1) begin
               if (m == int'(JAN)) begin
                  d = DAY_TOP;
                  m = DEC;
                  y = y - 1;
               end else begin
                  m = m - 1;
                  d = days_in_month(m, y);
               end
            end else begin
               d = d - 1;
            end
         end
         default: ;
      endcase
      rd = clip(d, int'(DAY_TOP));
      rm = clip(m, int'(MONTH_TOP));
      ry = clip(y, int'(YEAR_TOP));
      over = (rd != d) || (rm != m) || (ry != y);
      r.day   = rd[DAY_W-1:0];
      r.month = rm[MONTH_W-1:0];
      r.year  = ry[YEAR_W-1:0];
      r.valid = !over && ry >= int'(YEAR_MIN) && ry <= int'(YEAR_MAX)
                && rm >= 1 && rm <= 12 && rd >= 1 && rd <= days_in_month(rm, ry);
      return r;
   endfunction

   initial begin
      fail_count    = 0;
      pending       = 0;
      dates_checked = 0;
   end

   always @(posedge clock) begin
      date_t want;
      if (!reset) begin
         if ($isunknown(rsp_strobe)) begin
            $error("rsp_strobe is unknown");
            fail_count <= fail_count + 1;
         end else if (rsp_strobe) begin
            if (expected_dates.size() == 0) begin
               $error("result with no request outstanding: day %0d month %0d year %0d",
                      rsp_out_day, rsp_out_month, rsp_out_year);
               fail_count <= fail_count + 1;
            end else begin
               want = expected_dates.pop_front();
               dates_checked <= dates_checked + 1;
               if (rsp_out_day !== want.day ||
                   rsp_out_month !== want.month ||
                   rsp_out_year !== want.year ||
                   rsp_result_valid !== want.valid) begin
                  fail_count <= fail_count + 1;
                  if (rsp_out_day !== want.day)
                     $error("out_day: expected %0d, actual %0d", want.day, rsp_out_day);
                  if (rsp_out_month !== want.month)
                     $error("out_month: expected %0d, actual %0d", want.month, rsp_out_month);
                  if (rsp_out_year !== want.year)
                     $error("out_year: expected %0d, actual %0d", want.year, rsp_out_year);
                  if (rsp_result_valid !== want.valid)
                     $error("result_valid: expected %0d, actual %0d",
                            want.valid, rsp_result_valid);
               end
            end
         end
         if (start && !busy)
            expected_dates.push_back(step_date(mode_type'(req_mode), req_day,
                                               req_month, req_year));
      end
      pending <= expected_dates.size();
   end

endmodule

// ===== bench/tb.sv =====
// Testbench top for the Gregorian date stepper: clock, reset, request stimulus and verdict.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   logic                        clock;
   logic                        reset;
   logic                        start;
   logic                        busy;
   logic [1:0]                  req_mode;
   logic [gds_pkg::DAY_W-1:0]   req_day;
   logic [gds_pkg::MONTH_W-1:0] req_month;
   logic [gds_pkg::YEAR_W-1:0]  req_year;
   logic                        rsp_strobe;
   logic [gds_pkg::DAY_W-1:0]   rsp_out_day;
   logic [gds_pkg::MONTH_W-1:0] rsp_out_month;
   logic [gds_pkg::YEAR_W-1:0]  rsp_out_year;
   logic                        rsp_result_valid;

   int fail_count;
   int pending;
   int dates_checked;
   int mode_count[4];
   bit burst;

   gregorian_date_step_core i_dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_mode         (req_mode),
      .req_day          (req_day),
      .req_month        (req_month),
      .req_year         (req_year),
      .rsp_strobe       (rsp_strobe),
      .rsp_out_day      (rsp_out_day),
      .rsp_out_month    (rsp_out_month),
      .rsp_out_year     (rsp_out_year),
      .rsp_result_valid (rsp_result_valid)
   );

   gds_date_checker i_checker (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_mode         (req_mode),
      .req_day          (req_day),
      .req_month        (req_month),
      .req_year         (req_year),
      .rsp_strobe       (rsp_strobe),
      .rsp_out_day      (rsp_out_day),
      .rsp_out_month    (rsp_out_month),
      .rsp_out_year     (rsp_out_year),
      .rsp_result_valid (rsp_result_valid),
      .fail_count       (fail_count),
      .pending          (pending),
      .dates_checked    (dates_checked)
   );

   initial clock = 1'b0;
   always #10 clock = ~clock;

   task automatic send_request(gds_pkg::mode_type mode, int d, int m, int y);
      int gap;
      gap = burst ? 0 : $urandom_range(0, 7);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start     <= 1'b1;
      req_mode  <= mode;
      req_day   <= d[gds_pkg::DAY_W-1:0];
      req_month <= m[gds_pkg::MONTH_W-1:0];
      req_year  <= y[gds_pkg::YEAR_W-1:0];
      @(posedge clock);
      while (busy) @(posedge clock);
      mode_count[mode]++;
   endtask

   // hold off until every outstanding date has come back
   task automatic drain();
      start <= 1'b0;
      do @(posedge clock); while (pending != 0);
   endtask

   task automatic send_random();
      gds_pkg::mode_type mode;
      int d;
      int m;
      int y;
      int pick;
      pick = $urandom_range(0, 9);
      mode = (pick < 4) ? gds_pkg::MODE_NEXT : (pick < 8) ? gds_pkg::MODE_PREV :
             (pick < 9) ? gds_pkg::MODE_CHECK : gds_pkg::MODE_SPARE;
      if ($urandom_range(0, 4) == 0) begin
         d = $urandom_range(0, 31);
         m = $urandom_range(0, 15);
         y = $urandom_range(0, 32767);
      end else begin
         m = $urandom_range(1, 12);
         case ($urandom_range(0, 2))
            0:       d = 1;
            1:       d = $urandom_range(28, 31);
            default: d = $urandom_range(1, 31);
         endcase
         case ($urandom_range(0, 4))
            0:       y = $urandom_range(1900, 2500);
            1:       y = $urandom_range(1895, 1905);
            2:       y = $urandom_range(29995, 30005);
            3:       y = 100 * $urandom_range(19, 299) + $urandom_range(0, 8) - 4;
            default: y = $urandom_range(1900, 30000);
         endcase
      end
      send_request(mode, d, m, y);
   endtask

   initial begin
      reset     = 1'b1;
      start     = 1'b0;
      req_mode  = '0;
      req_day   = '0;
      req_month = '0;
      req_year  = '0;
      burst     = 1'b0;
      foreach (mode_count[k]) mode_count[k] = 0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      send_request(gds_pkg::MODE_NEXT,  31, 12, 1999);
      send_request(gds_pkg::MODE_NEXT,  28,  2, 2000);
      send_request(gds_pkg::MODE_NEXT,  28,  2, 1900);
      send_request(gds_pkg::MODE_NEXT,  29,  2, 2024);
      send_request(gds_pkg::MODE_PREV,   1,  3, 2000);
      send_request(gds_pkg::MODE_PREV,   1,  3, 2100);
      send_request(gds_pkg::MODE_PREV,   1,  1, 1900);
      send_request(gds_pkg::MODE_NEXT,  31, 12, 30000);
      send_request(gds_pkg::MODE_NEXT,  31, 12, 32767);
      send_request(gds_pkg::MODE_PREV,   1,  1, 0);
      send_request(gds_pkg::MODE_NEXT,  31,  1, 2023);
      send_request(gds_pkg::MODE_NEXT,   0,  0, 2000);
      send_request(gds_pkg::MODE_NEXT,   0, 13, 2000);
      send_request(gds_pkg::MODE_NEXT,   0, 15, 2000);
      send_request(gds_pkg::MODE_PREV,   1,  0, 2000);
      send_request(gds_pkg::MODE_PREV,   0,  5, 2000);
      send_request(gds_pkg::MODE_NEXT,  31,  0, 2000);
      send_request(gds_pkg::MODE_SPARE, 15,  6, 2012);
      send_request(gds_pkg::MODE_CHECK, 29,  2, 2100);
      send_request(gds_pkg::MODE_CHECK, 31,  4, 2001);
      send_request(gds_pkg::MODE_CHECK, 31, 15, 32767);
      send_request(gds_pkg::MODE_CHECK,  0,  0, 0);
      send_request(gds_pkg::MODE_PREV,   1, 13, 2000);
      send_request(gds_pkg::MODE_CHECK, 31, 12, 30000);
      drain();

      for (int i = 0; i < 1700; i++) begin
         if (i % 100 == 0)
            burst = ($urandom_range(0, 3) == 0);
         if (i == 850)
            drain();
         send_random();
      end

      drain();
      repeat (8) @(posedge clock);
      $display("Sent %0d next-day, %0d previous-day, %0d check and %0d spare-mode requests;",
               mode_count[gds_pkg::MODE_NEXT], mode_count[gds_pkg::MODE_PREV],
               mode_count[gds_pkg::MODE_CHECK], mode_count[gds_pkg::MODE_SPARE]);
      $display("compared %0d result dates, %0d mismatches.", dates_checked, fail_count);
      if (fail_count == 0 && pending == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("TEST FAILED");
      $finish;
   end

endmodule
